FILE: design/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = RING_AW + 1;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FLAG_W     = BYTE_W + 1;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned REM_W      = LEN_W + 1;
  localparam int unsigned MAX_OUT_W  = 24;

  localparam logic [RING_AW-1:0] START_POS = RING_AW'(4078);
  localparam logic [REM_W-1:0]   LEN_BIAS  = REM_W'(3);
  localparam logic [REM_W-1:0]   MAX_LEN   = REM_W'(18);

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [RING_AW-1:0]    ring_addr_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [MAX_OUT_W-1:0]  max_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

endpackage : lzss_pkg

`default_nettype wire

FILE: design/lzss_if.sv
`default_nettype none

interface lzss_in_if;
  logic                 valid;
  logic                 ready;
  lzss_pkg::byte_t      in_byte;
  logic                 start_stream;

  modport source (output valid, output in_byte, output start_stream, input ready);
  modport sink   (input valid, input in_byte, input start_stream, output ready);
endinterface : lzss_in_if

interface lzss_out_if;
  logic                 valid;
  logic                 ready;
  lzss_pkg::byte_t      out_byte;
  logic                 last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface : lzss_out_if

`default_nettype wire

FILE: design/lzss_ring_decoder_unit.sv
// Channel   Dir   Payload                       Transfer
// in_s      in    in_byte[8], start_stream[1]   valid && ready
// out_s     out   out_byte[8], last_of_run[1]   valid && ready
// cfg       in    cfg_wdata_i[24] (max_output)  cfg_we_i
//
// Flag byte, literal or first reference byte: taken while idle. A reference's
// second byte copies L+3 bytes via the single ring read port (read, then emit).
// Reset and stream start need no clearing pass: a fill count marks which ring
// entries this stream has written; all others read as zero.
// Input is ready only when the sequencer is idle and the output register is
// free or draining; a stalled output holds the sequencer.
`default_nettype none

module lzss_ring_decoder_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  lzss_in_if.sink                    in_s,
  lzss_out_if.source                 out_s,
  input  wire                        cfg_we_i,
  input  wire lzss_pkg::max_out_t    cfg_wdata_i
);

  lzss_pkg::state_e     state_q, state_d;
  lzss_pkg::ring_addr_t wp_q, wp_d;
  lzss_pkg::fill_t      fill_q, fill_d;
  lzss_pkg::count_t     cnt_q, cnt_d;
  logic [lzss_pkg::FLAG_W-1:0] flag_q, flag_d;
  logic                 phase_q, phase_d;
  lzss_pkg::byte_t      low_q, low_d;
  lzss_pkg::max_out_t   max_out_q;
  lzss_pkg::ring_addr_t copy_addr_q, copy_addr_d;
  logic [lzss_pkg::REM_W-1:0] rem_q, rem_d;
  logic                 rd_ok_q, rd_ok_d;
  lzss_pkg::byte_t      rd_data_q;
  logic                 out_valid_q, out_valid_d;
  lzss_pkg::byte_t      out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;

  logic                 out_free;
  logic                 in_fire;
  logic                 rd_en;
  logic                 mem_we;
  lzss_pkg::ring_addr_t mem_waddr;
  logic                 emit_en;
  lzss_pkg::byte_t      emit_byte;
  logic                 emit_last;
  logic                 limit_hit;
  lzss_pkg::ring_addr_t rd_offset;

  lzss_pkg::byte_t      ring_mem [lzss_pkg::RING_DEPTH];

  assign out_free     = !out_valid_q || out_s.ready;
  assign in_s.ready   = (state_q == lzss_pkg::ST_IDLE) && out_free;
  assign in_fire      = in_s.valid && in_s.ready;
  assign rd_offset    = copy_addr_q - lzss_pkg::START_POS;

  assign out_s.valid       = out_valid_q;
  assign out_s.out_byte    = out_byte_q;
  assign out_s.last_of_run = out_last_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;
    phase_d     = phase_q;
    low_d       = low_q;
    copy_addr_d = copy_addr_q;
    rem_d       = rem_q;
    rd_ok_d     = rd_ok_q;
    rd_en       = 1'b0;
    emit_en     = 1'b0;
    emit_byte   = in_s.in_byte;
    emit_last   = 1'b1;
    limit_hit   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wp_q;
    out_valid_d = out_valid_q && !out_s.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      lzss_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_s.start_stream) begin
            wp_d    = lzss_pkg::START_POS;
            fill_d  = '0;
            cnt_d   = '0;
            flag_d  = '0;
            phase_d = 1'b0;
            low_d   = '0;
          end
          limit_hit = (max_out_q != '0) && (cnt_d >= lzss_pkg::count_t'(max_out_q));
          if (phase_d) begin
            phase_d     = 1'b0;
            copy_addr_d = {in_s.in_byte[7:4], low_d};
            rem_d       = {1'b0, in_s.in_byte[lzss_pkg::LEN_W-1:0]} + lzss_pkg::LEN_BIAS;
            state_d     = lzss_pkg::ST_READ;
          end else if (flag_d[lzss_pkg::FLAG_W-1:1] == '0) begin
            flag_d = {1'b1, in_s.in_byte};
          end else if (!limit_hit) begin
            if (flag_d[0]) begin
              emit_en   = 1'b1;
              emit_byte = in_s.in_byte;
              emit_last = 1'b1;
            end else begin
              low_d   = in_s.in_byte;
              phase_d = 1'b1;
            end
            flag_d = flag_d >> 1;
          end
        end
      end
      lzss_pkg::ST_READ: begin
        rd_en   = 1'b1;
        rd_ok_d = {1'b0, rd_offset} < fill_q;
        state_d = lzss_pkg::ST_EMIT;
      end
      lzss_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_en     = 1'b1;
          emit_byte   = rd_ok_q ? rd_data_q : '0;
          emit_last   = (rem_q == lzss_pkg::REM_W'(1));
          copy_addr_d = copy_addr_q + lzss_pkg::RING_AW'(1);
          rem_d       = rem_q - lzss_pkg::REM_W'(1);
          state_d     = emit_last ? lzss_pkg::ST_IDLE : lzss_pkg::ST_READ;
        end
      end
      default: state_d = lzss_pkg::ST_IDLE;
    endcase

    if (emit_en) begin
      mem_we      = 1'b1;
      mem_waddr   = wp_d;
      wp_d        = wp_d + lzss_pkg::RING_AW'(1);
      if (fill_d != lzss_pkg::FILL_W'(lzss_pkg::RING_DEPTH)) begin
        fill_d = fill_d + lzss_pkg::FILL_W'(1);
      end
      if (cnt_d != '1) begin
        cnt_d = cnt_d + lzss_pkg::COUNT_BITS'(1);
      end
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzss_pkg::ST_IDLE;
      wp_q        <= lzss_pkg::START_POS;
      fill_q      <= '0;
      cnt_q       <= '0;
      flag_q      <= '0;
      phase_q     <= 1'b0;
      low_q       <= '0;
      max_out_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      flag_q      <= flag_d;
      phase_q     <= phase_d;
      low_q       <= low_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_out_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= copy_addr_d;
    rd_ok_q     <= rd_ok_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= emit_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= ring_mem[copy_addr_q];
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lzss_pkg::ST_IDLE) |-> !in_s.ready)
    else $error("input ready while a copy is in progress");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzss_pkg::ST_READ) |-> (rem_q != '0 && rem_q <= lzss_pkg::MAX_LEN))
    else $error("copy length out of range");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= lzss_pkg::FILL_W'(lzss_pkg::RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzss_pkg::ST_EMIT && out_free && rem_q == lzss_pkg::REM_W'(1))
    |=> (state_q == lzss_pkg::ST_IDLE && out_valid_q && out_last_q))
    else $error("final copied byte did not close the run");
`endif

endmodule : lzss_ring_decoder_unit

`default_nettype wire
